>>> design/signed_unsigned_divider_64_defines.svh
// Assertion macros used by the divider controller
`ifndef SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SUD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SUD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sud64_pkg.sv
// Package: field widths and controller/datapath command and status types
package sud64_pkg;

    // Width of every operand and result field on the channels
    localparam int FIELD_W = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a new word, form magnitudes
        logic step;   // one restoring shift-and-subtract step
        logic fix;    // sign fix-up into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic zero_div;   // incoming divisor is zero (in the active width)
    } t_sts;

endpackage

>>> design/sud64_if.sv
// Channel interfaces: operand word in, result word out
interface sud64_in_if;
    import sud64_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    logic               signed_mode;

    modport source (output valid, output dividend, output divisor, output signed_mode,
                    input ready);
    modport sink   (input valid, input dividend, input divisor, input signed_mode,
                    output ready);
endinterface

interface sud64_out_if;
    import sud64_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               div_by_zero;

    modport source (output valid, output quotient, output remainder, output div_by_zero,
                    input ready);
    modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                    output ready);
endinterface

>>> design/signed_unsigned_divider_64.sv
// Each word: operand accept, then one quotient bit per cycle in the restoring subtract loop,
// then the sign fix-up, which waits while the output register still holds an untaken result.
// A new operand word is taken only once the previous word has passed the sign fix-up.
// A zero divisor skips the loop and goes from accept straight to the sign fix-up.
// The next operand word is taken while a finished result waits in the output register.
// Reset: synchronous, active low; clears controller state and output valid, no flush pass.
module signed_unsigned_divider_64 #(
    parameter int DATA_WIDTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sud64_in_if.sink       i_in,
    sud64_out_if.source    o_out
);
    import sud64_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing
    sud64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic
    sud64_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_dividend    (i_in.dividend),
        .i_divisor     (i_in.divisor),
        .i_signed_mode (i_in.signed_mode),
        .o_quotient    (o_out.quotient),
        .o_remainder   (o_out.remainder),
        .o_div_by_zero (o_out.div_by_zero)
    );

endmodule

>>> design/sud64_ctrl.sv
// Divider controller: handshakes, step counter and sequencing state machine
`include "signed_unsigned_divider_64_defines.svh"

module sud64_ctrl #(
    parameter int DATA_WIDTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  sud64_pkg::t_sts i_sts,
    output sud64_pkg::t_cmd o_cmd
);
    import sud64_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;

    // Output register can take a word this cycle
    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && (r_state == S_IDLE);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Commands to the datapath
    always_comb begin
        o_cmd.load = accept;
        o_cmd.step = (r_state == S_RUN);
        o_cmd.fix  = (r_state == S_FIX) && out_free;
    end

    // Next state, counter and output valid
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt   = CNT_W'(DATA_WIDTH - 1);
                    n_state = i_sts.zero_div ? S_FIX : S_RUN;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Checks
    `SUD_ASSERT_NEXT(a_start_run, i_clk, i_rst_n, accept && !i_sts.zero_div, (r_state == S_RUN) && (r_cnt == CNT_W'(DATA_WIDTH - 1)), "run did not start with a full count")
    `SUD_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, (r_state == S_RUN) && (r_cnt == '0), r_state == S_FIX, "last step not followed by fix-up")
    `SUD_ASSERT_NEXT(a_fix_valid, i_clk, i_rst_n, o_cmd.fix, r_out_valid, "fixed-up result not presented")
    `SUD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid, "result word dropped while stalled")

endmodule

>>> design/sud64_dp.sv
// Divider datapath: magnitudes, restoring shift-and-subtract, sign fix-up
module sud64_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                          i_clk,
    input  sud64_pkg::t_cmd               i_cmd,
    output sud64_pkg::t_sts               o_sts,
    input  logic [sud64_pkg::FIELD_W-1:0] i_dividend,
    input  logic [sud64_pkg::FIELD_W-1:0] i_divisor,
    input  logic                          i_signed_mode,
    output logic [sud64_pkg::FIELD_W-1:0] o_quotient,
    output logic [sud64_pkg::FIELD_W-1:0] o_remainder,
    output logic                          o_div_by_zero
);
    import sud64_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W-1:0] a_in, b_in, a_mag, b_mag;
    logic         na, nb;
    logic [W:0]   trial;
    logic         q_bit;
    logic [W-1:0] rem_next;
    logic [W-1:0] q_fix, r_fix;

    logic [W-1:0] r_rem;
    logic [W-1:0] r_quo;      // dividend shifts out at the top, quotient in at the bottom
    logic [W-1:0] r_div;
    logic         r_neg_q, r_neg_r, r_zero;
    logic [W-1:0] r_q_out, r_r_out;
    logic         r_z_out;

    // Operands in the active width and their magnitudes
    assign a_in  = i_dividend[W-1:0];
    assign b_in  = i_divisor[W-1:0];
    assign na    = i_signed_mode && a_in[W-1];
    assign nb    = i_signed_mode && b_in[W-1];
    assign a_mag = na ? (~a_in + 1'b1) : a_in;
    assign b_mag = nb ? (~b_in + 1'b1) : b_in;

    assign o_sts.zero_div = (b_in == '0);

    // One restoring step: trial subtract of the divisor from the shifted remainder
    assign trial    = {r_rem, r_quo[W-1]} - {1'b0, r_div};
    assign q_bit    = !trial[W];
    assign rem_next = q_bit ? trial[W-1:0] : {r_rem[W-2:0], r_quo[W-1]};

    // Sign fix-up
    assign q_fix = r_neg_q ? (~r_quo + 1'b1) : r_quo;
    assign r_fix = r_neg_r ? (~r_rem + 1'b1) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= '0;
            r_quo   <= a_mag;
            r_div   <= b_mag;
            r_neg_q <= na ^ nb;
            r_neg_r <= na;
            r_zero  <= (b_in == '0);
        end else if (i_cmd.step) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[W-2:0], q_bit};
        end
        if (i_cmd.fix) begin
            r_q_out <= r_zero ? '0 : q_fix;
            r_r_out <= r_zero ? '0 : r_fix;
            r_z_out <= r_zero;
        end
    end

    assign o_quotient    = FIELD_W'(r_q_out);
    assign o_remainder   = FIELD_W'(r_r_out);
    assign o_div_by_zero = r_z_out;

endmodule
